>>> rtl/hpct_pkg.sv
// shared constants for the histogram peak color threshold block
`timescale 1ns / 1ps
`default_nettype none
package hpct_pkg;

  // default geometry
  localparam int NUM_BINS_DEF   = 180;
  localparam int COUNT_BITS_DEF = 22;

  // fixed field widths
  localparam int PEAK_BITS  = 8;
  localparam int PIX_BITS   = 8;
  localparam int HALF_BITS  = 7;
  localparam int CMD_BITS   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // commands
  localparam logic [CMD_BITS-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ACCUM    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLASSIFY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HALF_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_BELOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_ABOVE       = 3'd4;

  // register reset values
  localparam logic [HALF_BITS-1:0] HUE_HALF_WINDOW_RST = 7'd10;
  localparam logic [PIX_BITS-1:0]  VALUE_MAX_RST       = 8'd215;
  localparam logic [PIX_BITS-1:0]  SAT_BELOW_RST       = 8'd55;
  localparam logic [PIX_BITS-1:0]  SAT_ABOVE_RST       = 8'd50;

endpackage
`default_nettype wire

>>> rtl/hpct_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module hpct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/histogram_peak_color_threshold.sv
// top level: hsv histogram, peak search and peak-window color classifier
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------
//  input     start / busy           cmd, hue, sat, val, last
//  config    cfg_we                 cfg_idx, cfg_data
//  result    result_valid (strobe)  is_mask, peak_bin, mask
//
// clear and classify never leave idle; a classify result shows on the next cycle.
// accumulate reads the bin from the count ram, then writes it back in ST_ACC.
// a last accumulate adds the peak scan: one ram read per scanned bin, over bins
//   0 to NUM_BINS/2 - 1 in hue mode and 1 to NUM_BINS - 1 in saturation mode.
// busy is high while an accumulate or scan is in flight; the result strobe is
//   one cycle wide and cannot be held off.
// rst is synchronous; clear and reset empty the histogram at once via
//   per-bin valid flags, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module histogram_peak_color_threshold #(
  parameter int NUM_BINS   = hpct_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = hpct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [hpct_pkg::CMD_BITS-1:0]      cmd,
  input  wire logic [hpct_pkg::PIX_BITS-1:0]      hue,
  input  wire logic [hpct_pkg::PIX_BITS-1:0]      sat,
  input  wire logic [hpct_pkg::PIX_BITS-1:0]      val,
  input  wire logic                               last,
  input  wire logic                               cfg_we,
  input  wire logic [hpct_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [hpct_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    result_valid,
  output logic                                    is_mask,
  output logic [hpct_pkg::PEAK_BITS-1:0]          peak_bin,
  output logic                                    mask
);

  localparam int ADDR_W = $clog2(NUM_BINS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_SCAN,
    ST_SCAN_END
  } state_t;

  state_t state;

  // configuration
  logic                               channel_mode;
  logic [hpct_pkg::HALF_BITS-1:0]     hue_half_window;
  logic [hpct_pkg::PIX_BITS-1:0]      value_max;
  logic [hpct_pkg::PIX_BITS-1:0]      sat_below;
  logic [hpct_pkg::PIX_BITS-1:0]      sat_above;

  logic [hpct_pkg::PEAK_BITS-1:0]     peak_index;
  logic [NUM_BINS-1:0]                valid;
  logic                               vld_q;

  logic                               acc_hit;
  logic                               acc_last;
  logic [ADDR_W-1:0]                  acc_addr;

  logic [ADDR_W-1:0]                  scan_addr;
  logic [ADDR_W-1:0]                  scan_last;
  logic [ADDR_W-1:0]                  rd_idx;
  logic                               pend;
  logic                               first;
  logic [COUNT_BITS-1:0]              best_cnt;
  logic [ADDR_W-1:0]                  best_idx;

  logic                               accept;
  logic [hpct_pkg::PIX_BITS-1:0]      ch;
  logic                               ch_in_range;
  logic [ADDR_W-1:0]                  rd_addr;
  logic [COUNT_BITS-1:0]              ram_rdata;
  logic [COUNT_BITS-1:0]              cur_cnt;
  logic [COUNT_BITS-1:0]              acc_cnt;
  logic                               ram_we;
  logic                               take;
  logic [ADDR_W-1:0]                  peak_next;

  logic signed [9:0]                  win_x;
  logic signed [9:0]                  win_lo;
  logic signed [9:0]                  win_hi;
  logic signed [9:0]                  centre;
  logic                               mask_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  always_comb begin
    ch          = channel_mode ? sat : hue;
    ch_in_range = ({1'b0, ch} < 9'(NUM_BINS));
    rd_addr     = (state == ST_SCAN) ? scan_addr : ch[ADDR_W-1:0];
    cur_cnt     = vld_q ? ram_rdata : '0;
    acc_cnt     = (cur_cnt != {COUNT_BITS{1'b1}}) ? cur_cnt + COUNT_BITS'(1) : cur_cnt;
    ram_we      = (state == ST_ACC) && acc_hit;
    // first bin of the range always wins, later ones only when strictly larger
    take        = pend && (first || (cur_cnt > best_cnt));
    peak_next   = take ? rd_idx : best_idx;
  end

  always_comb begin
    centre = $signed({2'b00, peak_index});
    if (channel_mode) begin
      win_x  = $signed({2'b00, sat});
      win_lo = centre - $signed({2'b00, sat_below});
      win_hi = centre + $signed({2'b00, sat_above});
    end else begin
      win_x  = $signed({2'b00, hue});
      win_lo = centre - $signed({3'b000, hue_half_window});
      win_hi = centre + $signed({3'b000, hue_half_window});
    end
    mask_next = (win_x >= win_lo) && (win_x <= win_hi) && (val <= value_max);
  end

  hpct_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(acc_addr),
    .wdata(acc_cnt),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      result_valid    <= 1'b0;
      pend            <= 1'b0;
      valid           <= '0;
      vld_q           <= 1'b0;
      peak_index      <= '0;
      channel_mode    <= 1'b0;
      hue_half_window <= hpct_pkg::HUE_HALF_WINDOW_RST;
      value_max       <= hpct_pkg::VALUE_MAX_RST;
      sat_below       <= hpct_pkg::SAT_BELOW_RST;
      sat_above       <= hpct_pkg::SAT_ABOVE_RST;
    end else begin
      result_valid <= 1'b0;
      pend         <= 1'b0;
      vld_q        <= valid[rd_addr];

      if (cfg_we) begin
        unique case (cfg_idx)
          hpct_pkg::REG_CHANNEL_MODE:    channel_mode    <= cfg_data[0];
          hpct_pkg::REG_HUE_HALF_WINDOW: hue_half_window <= cfg_data[hpct_pkg::HALF_BITS-1:0];
          hpct_pkg::REG_VALUE_MAX:       value_max       <= cfg_data;
          hpct_pkg::REG_SAT_BELOW:       sat_below       <= cfg_data;
          hpct_pkg::REG_SAT_ABOVE:       sat_above       <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              hpct_pkg::CMD_CLEAR: begin
                valid <= '0;
              end
              hpct_pkg::CMD_ACCUM: begin
                acc_hit  <= ch_in_range;
                acc_addr <= ch[ADDR_W-1:0];
                acc_last <= last;
                state    <= ST_ACC;
              end
              hpct_pkg::CMD_CLASSIFY: begin
                result_valid <= 1'b1;
                is_mask      <= 1'b1;
                peak_bin     <= peak_index;
                mask         <= mask_next;
              end
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          if (acc_hit) begin
            valid[acc_addr] <= 1'b1;
          end
          if (acc_last) begin
            scan_addr <= ADDR_W'(channel_mode);
            scan_last <= channel_mode ? ADDR_W'(NUM_BINS - 1) : ADDR_W'(NUM_BINS / 2 - 1);
            first     <= 1'b1;
            state     <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          pend      <= 1'b1;
          rd_idx    <= scan_addr;
          scan_addr <= scan_addr + ADDR_W'(1);
          if (take) begin
            best_cnt <= cur_cnt;
            best_idx <= rd_idx;
          end
          if (pend) begin
            first <= 1'b0;
          end
          if (scan_addr == scan_last) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          peak_index   <= hpct_pkg::PEAK_BITS'(peak_next);
          result_valid <= 1'b1;
          is_mask      <= 1'b0;
          peak_bin     <= hpct_pkg::PEAK_BITS'(peak_next);
          mask         <= 1'b0;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/hpct_checker.sv
// port-level checks for the histogram peak color threshold block
`timescale 1ns / 1ps
`default_nettype none
module hpct_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [hpct_pkg::CMD_BITS-1:0]   cmd,
  input wire logic                            last,
  input wire logic                            result_valid,
  input wire logic                            is_mask,
  input wire logic                            mask
);

  // results only come out once the block has gone quiet
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while busy");

  // a classify beat answers on the very next cycle
  a_classify_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == hpct_pkg::CMD_CLASSIFY) |=> (result_valid && is_mask))
    else $error("classify result missing");

  // clear and plain accumulate beats produce nothing
  a_quiet_cmds: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == hpct_pkg::CMD_CLEAR ||
                        (cmd == hpct_pkg::CMD_ACCUM && !last))) |=> !result_valid)
    else $error("unexpected result");

  // a last accumulate always enters the peak scan
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == hpct_pkg::CMD_ACCUM && last) |=> busy)
    else $error("peak scan not started");

  // peak reports carry a zero mask
  a_peak_mask: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_mask) |-> !mask)
    else $error("peak report with mask set");

endmodule

bind histogram_peak_color_threshold hpct_checker u_hpct_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .cmd         (cmd),
  .last        (last),
  .result_valid(result_valid),
  .is_mask     (is_mask),
  .mask        (mask)
);
`default_nettype wire
